>>> sv/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
// Used by the channel interfaces, the controller and the top level; depends on nothing.
package bba_pkg;

  localparam int BLK_W         = 16;
  localparam int CNT_W         = 13;
  localparam int LIM_W         = 13;
  localparam int BYTE_W        = LIM_W - 3;
  localparam int ROOM_W        = BLK_W + 1;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int DEF_MAP_BYTES = 512;
  localparam logic [CNT_W-1:0] COUNT_RESET = 13'd4096;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_DATA_BLOCK = 1'b0,
    CFG_DATA_BLOCK_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [BLK_W-1:0] first_data_block;
    logic [LIM_W-1:0] limit;
  } cfg_t;

endpackage

>>> sv/bba_if.sv
// Request and response channel interfaces of the bitmap block allocator.
// Depends on bba_pkg for the field widths.
interface bba_req_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [BLK_W-1:0] block_number;

  modport source (output valid, output opcode, output block_number, input ready);
  modport sink   (input valid, input opcode, input block_number, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [BLK_W-1:0] block_number_out;

  modport source (output valid, output status, output block_number_out, input ready);
  modport sink   (input valid, input status, input block_number_out, output ready);
endinterface

>>> sv/bitmap_block_allocator.sv
// First-fit free-block bitmap allocator: top level with configuration registers.
// Depends on bba_pkg, the channel interfaces and bba_ctrl.
//
// Each request transaction on req_i is an allocate (opcode 0) or a free (opcode 1) of
// block_number. Each produces exactly one response transaction on rsp_o carrying a status
// (ok, no free block, block outside the data region) and a block number.
// The bitmap lives in a MapBytes x 8 synchronous RAM. An allocate reads one bitmap byte per
// cycle from byte zero upward and stops at the first byte that holds a clear bit below the
// usable limit, then sets that bit in the same cycle. A free reads its byte and writes it
// back with the bit cleared.
// From request acceptance, a rejected request (a free outside the region, or an allocate
// when the usable region is empty) goes straight to the response stage; a free reads its
// byte and then writes it back; an allocate inspects at most limit / 8 rounded up bytes.
// Each result is then loaded into the response register.
// The next request is taken at the same edge at which the previous response can first be
// taken, so the block does not take a new request before it is through with the last one.
// After reset the block runs a clearing pass, writing zero to every byte;
// req_i.ready stays low during it. Configuration writes are taken at any time.
// A stalled receiver holds the response register; the block still accepts one further
// request and finishes it, then waits until the pending response is taken.
module bitmap_block_allocator #(
  parameter int MapBytes = bba_pkg::DEF_MAP_BYTES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bba_req_if.sink                        req_i,
  bba_rsp_if.source                      rsp_o
);
  import bba_pkg::*;

  localparam int Cap = MapBytes * 8;

  logic [BLK_W-1:0]  first_q, first_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ROOM_W-1:0] room;
  logic [LIM_W-1:0]  lim_cap;
  logic [LIM_W-1:0]  limit;
  cfg_t              cfg;

  // Register writes; there is no read-back path.
  always_comb begin
    first_d = first_q;
    count_d = count_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST_DATA_BLOCK: first_d = cfg_data_i;
        CFG_DATA_BLOCK_COUNT: count_d = cfg_data_i[CNT_W-1:0];
        default: begin
          first_d = first_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      count_q <= COUNT_RESET;
    end else begin
      first_q <= first_d;
      count_q <= count_d;
    end
  end

  // The usable limit is the smallest of the block count, the bitmap size and the
  // room left in the 16-bit block number space above the first data block.
  assign room    = {1'b1, {BLK_W{1'b0}}} - {1'b0, first_q};
  assign lim_cap = (Cap < int'(count_q)) ? LIM_W'(Cap) : count_q;
  assign limit   = (ROOM_W'(lim_cap) > room) ? room[LIM_W-1:0] : lim_cap;

  assign cfg.first_data_block = first_q;
  assign cfg.limit            = limit;

  bba_ctrl #(
    .MapBytes (MapBytes)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

  // One request at a time: acceptance takes the sequencer out of its idle state.
  ap_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another was in progress");

  // A response without a free block carries block number zero.
  ap_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == STATUS_FULL) |-> (rsp_o.block_number_out == '0))
    else $error("full response with nonzero block number");

  // Only the three defined status codes are ever returned.
  ap_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.status == STATUS_OK || rsp_o.status == STATUS_FULL ||
                     rsp_o.status == STATUS_RANGE))
    else $error("undefined response status");

endmodule

>>> sv/bba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used for the allocation bitmap.
module bba_ram #(
  parameter int Width = 8,
  parameter int Depth = 512
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bba_ctrl.sv
// Sequencer of the bitmap block allocator: clearing pass, byte scan, free and response register.
// Depends on bba_pkg, the channel interfaces and bba_ram.
module bba_ctrl #(
  parameter int MapBytes = bba_pkg::DEF_MAP_BYTES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bba_pkg::cfg_t cfg_i,
  bba_req_if.sink       req_i,
  bba_rsp_if.source     rsp_o
);
  import bba_pkg::*;

  localparam int AW = (MapBytes > 1) ? $clog2(MapBytes) : 1;

  state_e            state_q, state_d;
  logic [BYTE_W-1:0] scan_q, scan_d;
  logic [2:0]        bit_q, bit_d;
  logic [AW-1:0]     clr_q, clr_d;
  status_e           res_status_q, res_status_d;
  logic [BLK_W-1:0]  res_blk_q, res_blk_d;
  logic              rsp_valid_q;
  logic [1:0]        rsp_status_q;
  logic [BLK_W-1:0]  rsp_blk_q;
  logic              rsp_load;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [7:0]        mem_rdata;

  logic [BLK_W-1:0]  free_off;
  logic              free_in_range;
  logic [LIM_W-1:0]  scan_base;
  logic [LIM_W-1:0]  scan_rem;
  logic [7:0]        avail;
  logic [2:0]        pick;
  logic              found;
  logic              last_byte;
  logic [LIM_W-1:0]  alloc_off;
  logic [BLK_W-1:0]  alloc_blk;
  logic [BYTE_W-1:0] scan_nxt;

  bba_ram #(
    .Width (8),
    .Depth (MapBytes)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Range check of a free request against the usable region.
  assign free_off      = req_i.block_number - cfg_i.first_data_block;
  assign free_in_range = (req_i.block_number >= cfg_i.first_data_block) &&
                         (free_off < BLK_W'(cfg_i.limit));

  // Bit j of a byte (mask 128 >> j) is a candidate when clear and below the limit.
  assign scan_base = {scan_q, 3'b000};
  assign scan_rem  = cfg_i.limit - scan_base;
  assign last_byte = (scan_rem <= LIM_W'(8));
  assign scan_nxt  = scan_q + BYTE_W'(1);

  always_comb begin
    pick  = 3'd0;
    found = 1'b0;
    for (int j = 0; j < 8; j++) begin
      avail[j] = !mem_rdata[7-j] && (LIM_W'(j) < scan_rem);
    end
    for (int j = 7; j >= 0; j--) begin
      if (avail[j]) begin
        pick  = 3'(j);
        found = 1'b1;
      end
    end
  end

  assign alloc_off = {scan_q, pick};
  assign alloc_blk = cfg_i.first_data_block + BLK_W'(alloc_off);

  always_comb begin
    state_d      = state_q;
    scan_d       = scan_q;
    bit_d        = bit_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_blk_d    = res_blk_q;
    rsp_load     = 1'b0;
    req_i.ready  = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = AW'(scan_q);
    mem_wdata    = 8'h00;
    mem_re       = 1'b0;
    mem_raddr    = AW'(scan_q);
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(MapBytes - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          if (req_i.opcode == OP_ALLOC) begin
            if (cfg_i.limit == '0) begin
              res_status_d = STATUS_FULL;
              res_blk_d    = '0;
              state_d      = ST_DONE;
            end else begin
              scan_d    = '0;
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_d   = ST_SCAN;
            end
          end else begin
            res_blk_d = req_i.block_number;
            if (!free_in_range) begin
              res_status_d = STATUS_RANGE;
              state_d      = ST_DONE;
            end else begin
              res_status_d = STATUS_OK;
              scan_d       = free_off[LIM_W-1:3];
              bit_d        = free_off[2:0];
              mem_re       = 1'b1;
              mem_raddr    = AW'(free_off[LIM_W-1:3]);
              state_d      = ST_FREE;
            end
          end
        end
      end
      ST_SCAN: begin
        if (found) begin
          mem_we       = 1'b1;
          mem_wdata    = mem_rdata | (8'h80 >> pick);
          res_status_d = STATUS_OK;
          res_blk_d    = alloc_blk;
          state_d      = ST_DONE;
        end else if (last_byte) begin
          res_status_d = STATUS_FULL;
          res_blk_d    = '0;
          state_d      = ST_DONE;
        end else begin
          scan_d    = scan_nxt;
          mem_re    = 1'b1;
          mem_raddr = AW'(scan_nxt);
        end
      end
      ST_FREE: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata & ~(8'h80 >> bit_q);
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    bit_q        <= bit_d;
    res_status_q <= res_status_d;
    res_blk_q    <= res_blk_d;
    if (rsp_load) begin
      rsp_status_q <= res_status_q;
      rsp_blk_q    <= res_blk_q;
    end
  end

  assign rsp_o.valid            = rsp_valid_q;
  assign rsp_o.status           = rsp_status_q;
  assign rsp_o.block_number_out = rsp_blk_q;

endmodule

>>> bench/bitmap_block_allocator_test.sv
// Self-checking testbench of the first-fit bitmap block allocator.
// Depends on bba_pkg, the bba_req_if and bba_rsp_if channels and bitmap_block_allocator.
module bitmap_block_allocator_test;
  import bba_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MapBits    = DEF_MAP_BYTES * 8;
  localparam int CycleLimit = 3_000_000;
  localparam int PhaseItems = 106;
  localparam int RandPhases = 11;

  // One request waiting to be sent, and one response the bitmap must produce.
  typedef struct {
    op_e              op;
    logic [BLK_W-1:0] blk;
  } block_request_t;

  typedef struct {
    status_e          status;
    logic [BLK_W-1:0] blk;
  } block_response_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  cfg_idx_e         cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  bba_req_if req_ch ();
  bba_rsp_if rsp_ch ();

  bitmap_block_allocator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_ch),
    .rsp_o      (rsp_ch)
  );

  // Requests the driver still has to present, and the responses the bitmap owes,
  // oldest first.
  block_request_t  requests_to_send[$];
  block_response_t responses_owed[$];

  // Our own copy of the bitmap and of the two registers. A set bit is a block in use.
  logic [7:0]       block_map [DEF_MAP_BYTES];
  logic [BLK_W-1:0] base_block;
  logic [CNT_W-1:0] block_count;

  int   mismatch_count;
  int   cycle_count;
  logic quiet_phase;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Number of bitmap bits that can be handed out: the block count, the size of the
  // map and the room left up to block 65535 all bound it.
  function automatic int usable_span();
    int span;
    int room;
    span = int'(block_count);
    room = 65536 - int'(base_block);
    if (span > MapBits) span = MapBits;
    if (room < span) span = room;
    return span;
  endfunction

  // Applies one request to the bitmap copy and returns the response it must cause.
  // Within a byte, bit zero of the map sits in the most significant position.
  function automatic block_response_t bitmap_outcome(op_e op, logic [BLK_W-1:0] blk);
    block_response_t rsp;
    int              span;
    int              idx;
    int              offset;
    logic            found;
    span  = usable_span();
    found = 1'b0;
    if (op == OP_ALLOC) begin
      rsp.status = STATUS_FULL;
      rsp.blk    = '0;
      for (idx = 0; idx < span && !found; idx++) begin
        if (!block_map[idx >> 3][7 - (idx & 7)]) begin
          block_map[idx >> 3][7 - (idx & 7)] = 1'b1;
          rsp.status = STATUS_OK;
          rsp.blk    = base_block + idx[BLK_W-1:0];
          found      = 1'b1;
        end
      end
    end else begin
      offset  = int'(blk) - int'(base_block);
      rsp.blk = blk;
      if (offset < 0 || offset >= span) begin
        rsp.status = STATUS_RANGE;
      end else begin
        // Freeing a block that is already free leaves it free and still reports ok.
        block_map[offset >> 3][7 - (offset & 7)] = 1'b0;
        rsp.status = STATUS_OK;
      end
    end
    return rsp;
  endfunction

  task automatic queue_request(op_e op, logic [BLK_W-1:0] blk);
    block_request_t req;
    req.op  = op;
    req.blk = blk;
    requests_to_send.push_back(req);
  endtask

  // Waits until every queued request has been taken and answered. Each request causes
  // exactly one response, so an empty response queue means the block is idle; the closing
  // wait covers the return of its control to the idle state.
  task automatic drain();
    @(negedge clk_i);
    while (requests_to_send.size() != 0 || req_ch.valid || responses_owed.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    // Only the low bits of the count register are kept.
    if (idx == CFG_FIRST_DATA_BLOCK) begin
      base_block = value;
    end else begin
      block_count = value[CNT_W-1:0];
    end
  endtask

  // Registers are only written once the block has gone idle.
  task automatic set_config(logic [CFG_DATA_W-1:0] first, logic [CFG_DATA_W-1:0] count);
    drain();
    write_register(CFG_FIRST_DATA_BLOCK, first);
    write_register(CFG_DATA_BLOCK_COUNT, count);
  endtask

  // Request driver. A new transaction is presented once the previous one has been
  // accepted or nothing is on the channel; about 6 in 100 chances to present a request are
  // left unused, except in the quiet phase.
  always @(posedge clk_i) begin : drive_requests
    block_request_t next_req;
    if (rst_ni) begin
      if (!req_ch.valid || req_ch.ready) begin
        if (requests_to_send.size() != 0 && (quiet_phase || $urandom_range(99) >= 6)) begin
          next_req = requests_to_send.pop_front();
          req_ch.valid        <= 1'b1;
          req_ch.opcode       <= next_req.op;
          req_ch.block_number <= next_req.blk;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every accepted request is run through the bitmap copy at once, and every
  // accepted response is checked against the oldest response still owed. The
  // response side stalls at random the same way the request side idles.
  always @(posedge clk_i) begin : watch_channels
    block_response_t owed;
    rsp_ch.ready <= quiet_phase || ($urandom_range(99) >= 6);
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        responses_owed.push_back(bitmap_outcome(op_e'(req_ch.opcode), req_ch.block_number));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (responses_owed.size() == 0) begin
          $error("response transaction with none owed: status %0d, block_number_out %0d",
                 rsp_ch.status, rsp_ch.block_number_out);
          mismatch_count++;
        end else begin
          owed = responses_owed.pop_front();
          if (rsp_ch.status !== owed.status) begin
            $error("status: expected %0d, actual %0d", owed.status, rsp_ch.status);
            mismatch_count++;
          end
          if (rsp_ch.block_number_out !== owed.blk) begin
            $error("block_number_out: expected %0d, actual %0d",
                   owed.blk, rsp_ch.block_number_out);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Watchdog. The limit is several times the slowest correct run, in which every
  // allocate would scan the whole map.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int span;
    int pick;
    int phase;
    int n;
    logic [CFG_DATA_W-1:0] first;
    logic [CFG_DATA_W-1:0] count;

    // Every input of the block is known from time zero on.
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_FIRST_DATA_BLOCK;
    cfg_data            = '0;
    req_ch.valid        = 1'b0;
    req_ch.opcode       = OP_ALLOC;
    req_ch.block_number = '0;
    rsp_ch.ready        = 1'b0;
    quiet_phase         = 1'b0;
    mismatch_count      = 0;
    cycle_count         = 0;
    base_block          = '0;
    block_count         = COUNT_RESET;
    foreach (block_map[b]) block_map[b] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers at their reset values: the lowest blocks come out first, frees of
    // free blocks are accepted, and frees beyond the region are rejected. The block
    // number of an allocate is ignored, so it carries extreme values.
    queue_request(OP_ALLOC, 16'hFFFF);
    queue_request(OP_ALLOC, 16'h0000);
    queue_request(OP_FREE, 16'd0);
    queue_request(OP_ALLOC, 16'h5555);
    queue_request(OP_FREE, 16'd0);
    queue_request(OP_FREE, 16'd0);
    queue_request(OP_FREE, 16'd4095);
    queue_request(OP_FREE, 16'd4096);
    queue_request(OP_FREE, 16'hFFFF);
    queue_request(OP_ALLOC, 16'hAAAA);

    // An empty region: every allocate reports no free block, every free is out of range.
    set_config(16'd0, 16'd0);
    queue_request(OP_ALLOC, 16'd0);
    queue_request(OP_FREE, 16'd0);

    // Region pinned against the top of the block numbers: the count (with its upper
    // data bits set) is cut down to a single usable bit.
    set_config(16'hFFFF, 16'hFFFF);
    queue_request(OP_FREE, 16'hFFFF);
    queue_request(OP_ALLOC, 16'd0);
    queue_request(OP_ALLOC, 16'd0);
    queue_request(OP_FREE, 16'hFFFE);

    // One byte of map: fill it, run out, free one block and take it again.
    set_config(16'd1000, 16'd8);
    for (n = 0; n < 7; n++) queue_request(OP_ALLOC, 16'($urandom));
    queue_request(OP_FREE, 16'd1003);
    queue_request(OP_ALLOC, 16'd0);

    // Random phases. Most regions are small, so that they fill up, full bytes get
    // skipped and allocates run out; now and then the whole map or a region near the
    // top of the block numbers is used. The map is kept across phases.
    for (phase = 0; phase < RandPhases; phase++) begin
      pick = $urandom_range(9);
      if (phase == 0 || pick == 7) begin
        count = 16'd4096;
      end else if (pick == 8) begin
        count = 16'($urandom);
      end else if (pick == 9) begin
        count = 16'($urandom_range(3));
      end else if (pick == 6) begin
        count = 16'($urandom_range(600, 65));
      end else begin
        count = 16'($urandom_range(64, 1));
      end
      // The upper data bits of a count write are dropped; set them now and then.
      count[15:13] = 3'($urandom);

      pick = $urandom_range(5);
      if (phase == 0 || pick == 0) begin
        first = 16'd0;
      end else if (pick == 1) begin
        first = 16'hFFFF - 16'($urandom_range(70));
      end else begin
        first = 16'($urandom);
      end

      set_config(first, count);
      // One phase runs with neither side idling.
      quiet_phase = (phase == 2);
      span = usable_span();

      for (n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(99);
        if (pick < 50) begin
          queue_request(OP_ALLOC, 16'($urandom));
        end else if (pick < 85 && span > 0) begin
          queue_request(OP_FREE, first + 16'($urandom_range(span - 1)));
        end else begin
          queue_request(OP_FREE, 16'($urandom));
        end
      end
    end

    drain();
    quiet_phase = 1'b0;
    // Stray responses after the last one owed would show up in the monitor here.
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
